// ----- rtl/core/xtea_block_encrypt_top_macros.svh -----
// ----------------------------------------------------------------------------
// XTEA block encrypt assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define XTEA_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Same-cycle implication.
`define XTEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XTEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/xtea_pkg.sv -----
// ----------------------------------------------------------------------------
// XTEA package
// Types, constants and elaboration-time helpers shared by the XTEA encrypt core.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned Rounds   = 32;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Delta = 32'h9E37_79B9;

  // One 64-bit block as two big-endian halves.
  typedef struct packed {
    word_t high;
    word_t low;
  } block_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0 = 2'd0,
    CfgKey1 = 2'd1,
    CfgKey2 = 2'd2,
    CfgKey3 = 2'd3
  } cfg_reg_e;

  // Running sum after the given number of delta additions, modulo 2^32.
  function automatic word_t round_sum(int unsigned num_adds);
    word_t adds;
    adds = word_t'(num_adds);
    return word_t'(adds * Delta);
  endfunction

endpackage

// ----- rtl/core/xtea_if.sv -----
// ----------------------------------------------------------------------------
// XTEA stream interfaces
// Valid/ready channels for plaintext words in and ciphertext words out.
// ----------------------------------------------------------------------------
interface xtea_plain_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  word_t plain_high;
  word_t plain_low;

  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface xtea_cipher_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  word_t cipher_high;
  word_t cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// ----- rtl/core/xtea_half_round.sv -----
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered Feistel half-round: updates either the high or the low half
// with a fixed running sum and the key word chosen for this stage.
// ----------------------------------------------------------------------------
module xtea_half_round #(
  parameter logic [31:0] SumConst    = '0,
  parameter bit          UpdateHigh  = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  xtea_pkg::block_t blk_i,
  input  xtea_pkg::word_t  key_i,
  output logic            valid_o,
  output xtea_pkg::block_t blk_o
);
  import xtea_pkg::*;

  word_t  src;
  word_t  mix;
  word_t  keyed;
  block_t blk_d;
  block_t blk_q;
  logic   valid_q;

  // The half that feeds the mix is the one not being updated.
  always_comb begin
    src   = UpdateHigh ? blk_i.low : blk_i.high;
    mix   = ((src << 4) ^ (src >> 5)) + src;
    keyed = mix ^ (SumConst + key_i);
    blk_d = blk_i;
    if (UpdateHigh) begin
      blk_d.high = blk_i.high + keyed;
    end else begin
      blk_d.low = blk_i.low + keyed;
    end
  end

  // Valid bit moves whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Data register loads only with a valid word.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

// ----- rtl/core/xtea_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// XTEA block encrypt top level
// Fully unrolled XTEA encryption pipeline with a key register file and an
// output register plus skid stage.
//
//   channel   dir  protocol      payload
//   plain_i   in   valid/ready   plain_high, plain_low (32 bits each)
//   cipher_o  out  valid/ready   cipher_high, cipher_low (32 bits each)
//   cfg       in   write only    cfg_we_i, cfg_index_i, cfg_wdata_i (key words)
//
// One word is accepted per cycle while ready is high; each round is two registered
// half-round stages, and a result passes all of them and the output register.
// Reset clears all valid bits and the key words; data registers are not reset.
// When the output is stalled, one more word drops into the skid register; then
// ready falls and the whole pipeline holds until the output drains.
// ----------------------------------------------------------------------------
module xtea_block_encrypt_top #(
  parameter int unsigned Rounds = xtea_pkg::Rounds
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  xtea_plain_if.sink                  plain_i,
  xtea_cipher_if.source               cipher_o,
  input  logic                        cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  xtea_pkg::word_t             cfg_wdata_i
);
  import xtea_pkg::*;

  localparam int unsigned NumStages = 2 * Rounds;

  word_t  key_q [KeyWords];
  logic   stage_vld [NumStages+1];
  block_t stage_blk [NumStages+1];
  logic   pipe_en;

  block_t out_blk_q;
  logic   out_vld_q;
  block_t skid_blk_q;
  logic   skid_vld_q;
  logic   out_fire;

  // Key register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgKey0: key_q[0] <= cfg_wdata_i;
        CfgKey1: key_q[1] <= cfg_wdata_i;
        CfgKey2: key_q[2] <= cfg_wdata_i;
        CfgKey3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances as long as the skid register is free.
  assign pipe_en       = !skid_vld_q;
  assign plain_i.ready = pipe_en;

  assign stage_vld[0]       = plain_i.valid;
  assign stage_blk[0].high  = plain_i.plain_high;
  assign stage_blk[0].low   = plain_i.plain_low;

  // Unrolled rounds: even stages update the high half, odd stages the low half.
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int unsigned Rnd     = s / 2;
    localparam bit          IsHigh  = (s % 2) == 0;
    localparam word_t       SumVal  = IsHigh ? round_sum(Rnd) : round_sum(Rnd + 1);
    localparam logic [1:0]  KeySel  = IsHigh ? SumVal[1:0] : SumVal[12:11];

    xtea_half_round #(
      .SumConst   (SumVal),
      .UpdateHigh (IsHigh)
    ) u_half_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (stage_vld[s]),
      .blk_i   (stage_blk[s]),
      .key_i   (key_q[KeySel]),
      .valid_o (stage_vld[s+1]),
      .blk_o   (stage_blk[s+1])
    );
  end

  assign out_fire = out_vld_q && cipher_o.ready;

  // Output register and skid valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= pipe_en && stage_vld[NumStages];
      end
    end else if (pipe_en && stage_vld[NumStages]) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Output register and skid data.
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_blk_q <= skid_blk_q;
      end else if (pipe_en && stage_vld[NumStages]) begin
        out_blk_q <= stage_blk[NumStages];
      end
    end else if (pipe_en && stage_vld[NumStages]) begin
      skid_blk_q <= stage_blk[NumStages];
    end
  end

  assign cipher_o.valid       = out_vld_q;
  assign cipher_o.cipher_high = out_blk_q.high;
  assign cipher_o.cipher_low  = out_blk_q.low;

endmodule

// ----- rtl/core/xtea_checker.sv -----
// ----------------------------------------------------------------------------
// XTEA port checker
// Tracks words in flight from the port handshakes and checks occupancy and
// output stability; bound to the top level.
// ----------------------------------------------------------------------------
`include "xtea_block_encrypt_top_macros.svh"

module xtea_checker #(
  parameter int unsigned Rounds = xtea_pkg::Rounds
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input xtea_pkg::word_t out_high_i,
  input xtea_pkg::word_t out_low_i
);
  import xtea_pkg::*;

  localparam int unsigned Cap  = 2 * Rounds + 2;
  localparam int unsigned CntW = $clog2(Cap + 2);

  logic [CntW-1:0] inflight_q;
  logic            in_fire;
  logic            out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Words accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(in_fire) - CntW'(out_fire);
    end
  end

  `XTEA_ASSERT_NOW(a_no_phantom_out, out_valid_i, inflight_q != '0, "result without input")
  `XTEA_ASSERT_NOW(a_ready_low_full, !in_ready_i, inflight_q >= CntW'(2), "ready low early")
  `XTEA_ASSERT_NOW(a_inflight_cap, 1'b1, inflight_q <= CntW'(Cap), "too many in flight")
  `XTEA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_high_i) && $stable(out_low_i), "stalled output changed")

endmodule

bind xtea_block_encrypt_top xtea_checker #(
  .Rounds (Rounds)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (plain_i.valid),
  .in_ready_i  (plain_i.ready),
  .out_valid_i (cipher_o.valid),
  .out_ready_i (cipher_o.ready),
  .out_high_i  (cipher_o.cipher_high),
  .out_low_i   (cipher_o.cipher_low)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// XTEA block encrypt testbench
// Streams plaintext words through the encrypt pipeline under a series of keys.
// An in-bench XTEA model predicts every ciphertext word, and a monitor checks
// each word against it in order. Both sides idle at random, and one phase holds
// the output off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  localparam int unsigned PipeLatency   = 2 * Rounds;
  localparam int unsigned DrainCycles   = PipeLatency + 8;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WordsPerPhase = 110;
  localparam int unsigned HoldPhase     = 2;
  localparam int unsigned MaxReports    = 20;

  localparam word_t AllOnes = 32'hFFFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  word_t             cfg_wdata;

  xtea_plain_if  plain_bus ();
  xtea_cipher_if cipher_bus ();

  xtea_block_encrypt_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .plain_i    (plain_bus),
    .cipher_o   (cipher_bus),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // Key as the block should hold it, plaintext waiting to be sent and
  // ciphertext waiting to come out.
  word_t  key_shadow [KeyWords];
  block_t plain_queue [$];
  block_t cipher_expect_q [$];

  logic        plain_fire = 1'b0;
  int unsigned sender_mode = 0;
  int unsigned receiver_mode = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned key_settings = 0;
  int unsigned idle_cycles = 0;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // One half of the Feistel round function.
  function automatic word_t round_mix(word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Full XTEA encryption of one block under the shadow key.
  function automatic block_t xtea_cipher(block_t plain);
    word_t  v0;
    word_t  v1;
    word_t  sum;
    block_t result;
    v0  = plain.high;
    v1  = plain.low;
    sum = '0;
    for (int unsigned r = 0; r < Rounds; r++) begin
      v0  = v0 + (round_mix(v1) ^ (sum + key_shadow[sum[1:0]]));
      sum = sum + Delta;
      v1  = v1 + (round_mix(v0) ^ (sum + key_shadow[sum[12:11]]));
    end
    result.high = v0;
    result.low  = v1;
    return result;
  endfunction

  // Gap length: mode 0 never idles, mode 1 idles lightly, mode 2 heavily.
  // Most gaps are short and a few are long.
  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) begin
      return 0;
    end else if (mode == 1) begin
      if (roll < 75) return 0;
      if (roll < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
    end else begin
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 100);
    end
  endfunction

  // Random word, biased now and then toward the corners of the range.
  function automatic word_t rand_word();
    word_t one_bit;
    one_bit = word_t'(1) << $urandom_range(0, WordW - 1);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return AllOnes;
      2: return one_bit;
      3: return ~one_bit;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Sender: offers the next queued word once the last one was taken.
  always @(negedge clk) begin
    block_t next_word;
    if (rst_n) begin
      if (!plain_bus.valid || plain_fire) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          plain_bus.valid <= 1'b0;
        end else if (plain_queue.size() > 0) begin
          next_word = plain_queue.pop_front();
          plain_bus.valid      <= 1'b1;
          plain_bus.plain_high <= next_word.high;
          plain_bus.plain_low  <= next_word.low;
          send_gap = pick_gap(sender_mode);
        end else begin
          plain_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left   = LongHold;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        cipher_bus.ready <= 1'b0;
      end else begin
        cipher_bus.ready <= 1'b1;
        stall_left = pick_gap(receiver_mode);
      end
    end
  end

  // Monitor: predicts on each accepted plaintext word and checks each
  // accepted ciphertext word against the oldest prediction.
  always @(posedge clk) begin
    block_t got;
    block_t want;
    plain_fire <= rst_n && plain_bus.valid && plain_bus.ready;
    if (rst_n) begin
      if (plain_bus.valid && !plain_bus.ready) input_stall_cycles++;
      if (cipher_bus.valid && cipher_bus.ready) begin
        got.high = cipher_bus.cipher_high;
        got.low  = cipher_bus.cipher_low;
        if (cipher_expect_q.size() == 0) begin
          if (mismatches < MaxReports)
            $display("%0t: unexpected ciphertext word %h_%h", $time, got.high, got.low);
          mismatches++;
        end else begin
          want = cipher_expect_q.pop_front();
          if (got.high !== want.high) begin
            if (mismatches < MaxReports)
              $display("%0t: cipher_high expected %h actual %h", $time, want.high, got.high);
            mismatches++;
          end
          if (got.low !== want.low) begin
            if (mismatches < MaxReports)
              $display("%0t: cipher_low expected %h actual %h", $time, want.low, got.low);
            mismatches++;
          end
          words_checked++;
        end
      end
      if (plain_bus.valid && plain_bus.ready) begin
        want.high = plain_bus.plain_high;
        want.low  = plain_bus.plain_low;
        cipher_expect_q = {cipher_expect_q, xtea_cipher(want)};
        words_sent++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((plain_bus.valid && plain_bus.ready) || (cipher_bus.valid && cipher_bus.ready) ||
          cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Writes one key register; the shadow key follows at once.
  task automatic write_cfg(cfg_reg_e idx, word_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    key_shadow[idx] = data;
  endtask

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_cfg(CfgKey0, k0);
    write_cfg(CfgKey1, k1);
    write_cfg(CfgKey2, k2);
    write_cfg(CfgKey3, k3);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    key_settings++;
  endtask

  task automatic send_block(word_t high, word_t low);
    block_t blk;
    blk.high = high;
    blk.low  = low;
    plain_queue = {plain_queue, blk};
  endtask

  // Corner plaintexts: all zeros, all ones, mixed halves, top and bottom bits, one random.
  task automatic send_corners();
    send_block('0, '0);
    send_block(AllOnes, AllOnes);
    send_block(AllOnes, '0);
    send_block('0, AllOnes);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(word_t'($urandom()), word_t'($urandom()));
  endtask

  // Waits until every word has gone out and the pipeline is empty.
  task automatic wait_drained();
    while (plain_queue.size() != 0 || plain_bus.valid || cipher_expect_q.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Stimulus: directed corners under three keys, then random phases.
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CfgKey0;
    cfg_wdata            = '0;
    plain_bus.valid      = 1'b0;
    plain_bus.plain_high = '0;
    plain_bus.plain_low  = '0;
    cipher_bus.ready     = 1'b0;
    for (int unsigned k = 0; k < KeyWords; k++) key_shadow[k] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The key is never written here, so it stays all zeros from reset.
    sender_mode   = 0;
    receiver_mode = 0;
    send_corners();
    wait_drained();

    sender_mode   = 1;
    receiver_mode = 1;
    load_key(AllOnes, AllOnes, AllOnes, AllOnes);
    send_corners();
    wait_drained();

    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    send_corners();
    wait_drained();

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      if (p == 0)
        load_key('0, '0, '0, '0);
      else if (p == 1)
        load_key(AllOnes, '0, AllOnes, '0);
      else
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
      sender_mode   = (p == HoldPhase) ? 0 : $urandom_range(0, 2);
      receiver_mode = $urandom_range(0, 2);
      for (int unsigned n = 0; n < WordsPerPhase; n++) send_block(rand_word(), rand_word());
      // Hold the output off while the sender keeps pushing, to fill the pipe.
      if (p == HoldPhase) hold_requests++;
      wait_drained();
    end

    $display("Sent %0d plaintext words under %0d key settings; %0d ciphertext words checked.",
             words_sent, key_settings + 1, words_checked);
    $display("The input was held back for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (mismatches == 0 && cipher_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
